>>> hw/rtl/lkv_pkg.sv
// Shared types and constants for the length-prefixed key/value deframer.
package lkv_pkg;

    localparam int FRAME_LEN_BITS_DEF = 24;
    localparam int LEN_BYTES          = 4;
    localparam int LEN_CNT_BITS       = 2;
    localparam int LEN_ACC_BITS       = 8 * (LEN_BYTES - 1);

    typedef enum logic [2:0] {
        PH_ABORT,
        PH_KLEN,
        PH_KEY,
        PH_VLEN,
        PH_VALUE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ABORT  = 2'd0,
        KIND_KEY    = 2'd1,
        KIND_VALUE  = 2'd2,
        KIND_STATUS = 2'd3
    } kind_t;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_OVERRUN = 1'b1;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        frame_start;
        logic [23:0] frame_length;
    } in_t;

    typedef struct packed {
        kind_t       out_kind;
        logic [7:0]  out_data;
        logic        record_end;
        logic        frame_end;
        logic        frame_status;
    } out_t;

endpackage

>>> hw/rtl/lkv_parser.sv
// Frame parser: per-word state update and result generation.
module lkv_parser #(
    parameter int FRAME_LEN_BITS = lkv_pkg::FRAME_LEN_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  lkv_pkg::in_t  word,
    output logic          emit,
    output lkv_pkg::out_t result
);
    import lkv_pkg::*;

    localparam int W  = FRAME_LEN_BITS;
    localparam int SW = ((W > 32) ? W : 32) + 2;

    phase_t                  phase_reg, phase_next;
    logic [W-1:0]            pos_reg, pos_next;
    logic [W-1:0]            tot_reg, tot_next;
    logic [LEN_ACC_BITS-1:0] acc_reg, acc_next;
    logic [LEN_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [31:0]             left_reg, left_next;
    logic                    fin_reg, fin_next;

    phase_t                  ph_e;
    logic [W-1:0]            pos_e, tot_e, tot_in, pos_inc;
    logic [LEN_ACC_BITS-1:0] acc_e, acc_add;
    logic [LEN_CNT_BITS-1:0] cnt_e;
    logic [31:0]             left_e, left_dec, len_full, fl_ext;
    logic                    fin_e, zero_start, active, bnd_done, len_last;
    logic                    len_zero, key_err, val_err, left_zero;
    logic [7:0]              b;

    assign b      = word.data_byte;
    assign fl_ext = 32'(word.frame_length);
    assign tot_in = fl_ext[W-1:0];

    always_comb begin
        if (word.frame_start) begin
            tot_e  = tot_in;
            pos_e  = '0;
            ph_e   = PH_ABORT;
            acc_e  = '0;
            cnt_e  = '0;
            left_e = '0;
            fin_e  = (tot_in == '0);
        end else begin
            tot_e  = tot_reg;
            pos_e  = pos_reg;
            ph_e   = phase_reg;
            acc_e  = acc_reg;
            cnt_e  = cnt_reg;
            left_e = left_reg;
            fin_e  = fin_reg;
        end
    end

    assign zero_start = word.frame_start && (tot_in == '0);
    assign active     = !fin_e;
    assign pos_inc    = pos_e + W'(1);
    assign bnd_done   = ({1'b0, pos_inc} + (W + 1)'(LEN_BYTES)) > {1'b0, tot_e};
    assign len_last   = (cnt_e == LEN_CNT_BITS'(LEN_BYTES - 1));
    assign len_full   = {b, acc_e};
    assign len_zero   = (len_full == '0);
    assign acc_add    = acc_e | (LEN_ACC_BITS'(b) << (8 * cnt_e));
    assign key_err    = (SW'(pos_inc) + SW'(len_full) + SW'(LEN_BYTES)) > SW'(tot_e);
    assign val_err    = (SW'(pos_inc) + SW'(len_full)) > SW'(tot_e);
    assign left_dec   = (left_e == '0) ? '0 : left_e - 32'd1;
    assign left_zero  = (left_dec == '0);

    // next state
    always_comb begin
        phase_next = ph_e;
        pos_next   = active ? pos_inc : pos_e;
        tot_next   = tot_e;
        acc_next   = acc_e;
        cnt_next   = cnt_e;
        left_next  = left_e;
        fin_next   = fin_e;
        if (active) begin
            unique case (ph_e)
                PH_ABORT: begin
                    if (bnd_done) begin
                        fin_next = 1'b1;
                    end else begin
                        phase_next = PH_KLEN;
                        acc_next   = '0;
                        cnt_next   = '0;
                    end
                end
                PH_KLEN: begin
                    if (!len_last) begin
                        acc_next = acc_add;
                        cnt_next = cnt_e + LEN_CNT_BITS'(1);
                    end else begin
                        acc_next = '0;
                        cnt_next = '0;
                        if (len_zero || key_err) begin
                            fin_next = 1'b1;
                        end else begin
                            left_next  = len_full;
                            phase_next = PH_KEY;
                        end
                    end
                end
                PH_KEY: begin
                    left_next = left_dec;
                    if (left_zero) begin
                        phase_next = PH_VLEN;
                        acc_next   = '0;
                        cnt_next   = '0;
                    end
                end
                PH_VLEN: begin
                    if (!len_last) begin
                        acc_next = acc_add;
                        cnt_next = cnt_e + LEN_CNT_BITS'(1);
                    end else begin
                        acc_next = '0;
                        cnt_next = '0;
                        if (val_err) begin
                            fin_next = 1'b1;
                        end else if (len_zero) begin
                            if (bnd_done) begin
                                fin_next = 1'b1;
                            end else begin
                                phase_next = PH_KLEN;
                            end
                        end else begin
                            left_next  = len_full;
                            phase_next = PH_VALUE;
                        end
                    end
                end
                PH_VALUE: begin
                    left_next = left_dec;
                    if (left_zero) begin
                        acc_next = '0;
                        cnt_next = '0;
                        if (bnd_done) begin
                            fin_next = 1'b1;
                        end else begin
                            phase_next = PH_KLEN;
                        end
                    end
                end
                default: begin
                    fin_next = 1'b1;
                end
            endcase
        end
    end

    // result
    always_comb begin
        emit                = 1'b0;
        result.out_kind     = KIND_STATUS;
        result.out_data     = '0;
        result.record_end   = 1'b0;
        result.frame_end    = 1'b0;
        result.frame_status = STATUS_OK;
        if (zero_start) begin
            emit                = 1'b1;
            result.frame_end    = 1'b1;
            result.frame_status = STATUS_OVERRUN;
        end else if (active) begin
            unique case (ph_e)
                PH_ABORT: begin
                    emit             = 1'b1;
                    result.out_kind  = KIND_ABORT;
                    result.out_data  = {7'd0, (b != 8'd0)};
                    result.frame_end = bnd_done;
                end
                PH_KLEN: begin
                    if (len_last && (len_zero || key_err)) begin
                        emit                = 1'b1;
                        result.frame_end    = 1'b1;
                        result.frame_status = len_zero ? STATUS_OK : STATUS_OVERRUN;
                    end
                end
                PH_KEY: begin
                    emit            = 1'b1;
                    result.out_kind = KIND_KEY;
                    result.out_data = b;
                end
                PH_VLEN: begin
                    if (len_last) begin
                        if (val_err) begin
                            emit                = 1'b1;
                            result.frame_end    = 1'b1;
                            result.frame_status = STATUS_OVERRUN;
                        end else if (len_zero) begin
                            emit              = 1'b1;
                            result.record_end = 1'b1;
                            result.frame_end  = bnd_done;
                        end
                    end
                end
                PH_VALUE: begin
                    emit            = 1'b1;
                    result.out_kind = KIND_VALUE;
                    result.out_data = b;
                    if (left_zero) begin
                        result.record_end = 1'b1;
                        result.frame_end  = bnd_done;
                    end
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_ABORT;
            pos_reg   <= '0;
            tot_reg   <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            left_reg  <= '0;
            fin_reg   <= 1'b1;
        end else if (accept) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            tot_reg   <= tot_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            left_reg  <= left_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

>>> hw/rtl/lkv_out_buf.sv
// Result register with skid stage on the output channel.
module lkv_out_buf (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lkv_pkg::out_t push_data,
    output logic          can_push,
    output logic          m_valid,
    input  logic          m_ready,
    output lkv_pkg::out_t m_data
);
    import lkv_pkg::*;

    out_t main_reg, skid_reg;
    logic main_valid_reg, skid_valid_reg;

    assign can_push = !skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_data   = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                main_reg <= skid_reg;
            end else if (push) begin
                main_reg <= push_data;
            end
        end else if (push) begin
            skid_reg <= push_data;
        end
    end

endmodule

>>> hw/rtl/length_prefixed_kv_deframer.sv
// Top level of the length-prefixed key/value deframer.
//
// Parses one payload word per clock while s_ready is high: every accepted word
// updates the parser state in the same cycle and its result (if any) lands in
// a registered output stage, so throughput is one word per cycle unless the
// output side stalls. A two-entry output buffer (result register plus skid
// register) lets s_ready stay high while the result side stalls, until the skid
// register fills; s_ready drops only while both entries are full. Frame length
// is taken from the low FRAME_LEN_BITS bits of frame_length on a start word.
module length_prefixed_kv_deframer #(
    parameter int FRAME_LEN_BITS = lkv_pkg::FRAME_LEN_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lkv_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lkv_pkg::out_t m_data
);
    import lkv_pkg::*;

    logic accept, emit, can_push;
    out_t result;

    assign s_ready = can_push;
    assign accept  = s_valid && can_push;

    lkv_parser #(
        .FRAME_LEN_BITS(FRAME_LEN_BITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .word    (s_data),
        .emit    (emit),
        .result  (result)
    );

    lkv_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && emit),
        .push_data (result),
        .can_push  (can_push),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
